[sv/skaf_pkg.sv]
`timescale 1ns / 1ps
package skaf_pkg;

  localparam int unsigned PeriodW = 24;
  localparam int unsigned NoiseW  = 31;
  localparam int unsigned DataW   = 32;
  localparam int unsigned GainW   = 17;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [PeriodW-1:0] PeriodReset = 24'd111848;
  localparam logic [NoiseW-1:0]  QnoiseReset = 31'd131072;
  localparam logic [NoiseW-1:0]  RnoiseReset = 31'd327680000;
  localparam logic [GainW-1:0]   GainOne     = 17'd65536;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgPeriod = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgQnoise = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRnoise = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DELTA, ST_PP, ST_QQ, ST_RR, ST_DSET, ST_DIV, ST_SQK_INIT,
    ST_SQK, ST_GAIN, ST_CORR, ST_LO, ST_HI, ST_SQP_INIT, ST_SQP, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD_IN, OP_MUL_DELTA, OP_MUL_PP, OP_MUL_QQ, OP_MUL_RR,
    OP_DIV_SET, OP_DIV_STEP, OP_SQRT_K_INIT, OP_SQRT_STEP, OP_GAIN,
    OP_MUL_CORR, OP_MUL_LO, OP_MUL_HI, OP_SQRT_P_INIT, OP_COMMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_skip;  // R*R/4 is zero: gain fraction settles without division
    logic out_free;  // output register can take a word this cycle
  } status_t;

endpackage

[sv/skaf_ctrl.sv]
`timescale 1ns / 1ps
module skaf_ctrl
  import skaf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_DELTA;
      ST_DELTA:    state_nxt = ST_PP;
      ST_PP:       state_nxt = ST_QQ;
      ST_QQ:       state_nxt = ST_RR;
      ST_RR:       state_nxt = ST_DSET;
      ST_DSET:     state_nxt = status.div_skip ? ST_SQK_INIT : ST_DIV;
      ST_DIV: begin
        cnt_nxt = cnt_r + 5'd1;
        if (&cnt_r) state_nxt = ST_SQK_INIT;
      end
      ST_SQK_INIT: state_nxt = ST_SQK;
      ST_SQK: begin
        cnt_nxt = cnt_r + 5'd1;
        if (&cnt_r) state_nxt = ST_GAIN;
      end
      ST_GAIN:     state_nxt = ST_CORR;
      ST_CORR:     state_nxt = ST_LO;
      ST_LO:       state_nxt = ST_HI;
      ST_HI:       state_nxt = ST_SQP_INIT;
      ST_SQP_INIT: state_nxt = ST_SQP;
      ST_SQP: begin
        cnt_nxt = cnt_r + 5'd1;
        if (&cnt_r) state_nxt = ST_DONE;
      end
      ST_DONE:     if (status.out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = 1'b1;
    cmd.op   = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd.op = OP_LOAD_IN;
      end
      ST_DELTA:    cmd.op = OP_MUL_DELTA;
      ST_PP:       cmd.op = OP_MUL_PP;
      ST_QQ:       cmd.op = OP_MUL_QQ;
      ST_RR:       cmd.op = OP_MUL_RR;
      ST_DSET:     cmd.op = OP_DIV_SET;
      ST_DIV:      cmd.op = OP_DIV_STEP;
      ST_SQK_INIT: cmd.op = OP_SQRT_K_INIT;
      ST_SQK:      cmd.op = OP_SQRT_STEP;
      ST_GAIN:     cmd.op = OP_GAIN;
      ST_CORR:     cmd.op = OP_MUL_CORR;
      ST_LO:       cmd.op = OP_MUL_LO;
      ST_HI:       cmd.op = OP_MUL_HI;
      ST_SQP_INIT: cmd.op = OP_SQRT_P_INIT;
      ST_SQP:      cmd.op = OP_SQRT_STEP;
      ST_DONE:     if (status.out_free) cmd.op = OP_COMMIT;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

[sv/skaf_dp.sv]
`timescale 1ns / 1ps
module skaf_dp
  import skaf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output status_t                  status,
  input  logic signed [DataW-1:0]  in_angle_rate,
  input  logic signed [DataW-1:0]  in_accel_angle,
  input  logic                     cfg_we,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [DataW-1:0]         cfg_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DataW-1:0]  out_fused_angle,
  output logic [GainW-1:0]         out_filter_gain
);

  logic [PeriodW-1:0]       period_r, period_nxt;
  logic [NoiseW-1:0]        qn_r, qn_nxt, rn_r, rn_nxt;
  logic signed [31:0]       est_r, est_nxt;
  logic [31:0]              dev_r, dev_nxt;
  logic signed [31:0]       rate_r, rate_nxt, meas_r, meas_nxt;
  logic signed [67:0]       prod_r, prod_nxt;
  logic signed [33:0]       prior_r, prior_nxt;
  logic [63:0]              var_r, var_nxt;
  logic [62:0]              rem_r, rem_nxt, den_r, den_nxt;
  logic [32:0]              frac_r, frac_nxt;
  logic [63:0]              sq_n_r, sq_n_nxt, sq_res_r, sq_res_nxt, sq_bit_r, sq_bit_nxt;
  logic [GainW-1:0]         gain_r, gain_nxt;
  logic signed [34:0]       diff_r, diff_nxt;
  logic signed [31:0]       fused_r, fused_nxt;
  logic [48:0]              acc_r, acc_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [31:0]       out_fused_r, out_fused_nxt;
  logic [GainW-1:0]         out_gain_r, out_gain_nxt;

  logic signed [34:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [67:0] mul_p;
  logic               mul_en;
  logic [GainW-1:0]   gain_c;

  logic signed [56:0] dsum;
  logic signed [32:0] delta;
  logic signed [52:0] csum;
  logic signed [36:0] corr, fused_w;
  logic [64:0]        var_sum;
  logic [61:0]        r2q;
  logic [63:0]        rem_sh, sq_t;
  logic               div_ge, sq_ge;

  assign gain_c = GainOne - gain_r;
  assign r2q    = prod_r[63:2];

  // shared multiplier, operands chosen by the command
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd.op)
      OP_MUL_DELTA: begin
        mul_a = 35'(rate_r);
        mul_b = {9'd0, period_r};
      end
      OP_MUL_PP: begin
        mul_a = {3'd0, dev_r};
        mul_b = {1'b0, dev_r};
      end
      OP_MUL_QQ: begin
        mul_a = {4'd0, qn_r};
        mul_b = {2'd0, qn_r};
      end
      OP_MUL_RR: begin
        mul_a = {4'd0, rn_r};
        mul_b = {2'd0, rn_r};
      end
      OP_MUL_CORR: begin
        mul_a = diff_r;
        mul_b = {16'd0, gain_r};
      end
      OP_MUL_LO: begin
        mul_a = {3'd0, var_r[47:16]};
        mul_b = {16'd0, gain_c};
      end
      OP_MUL_HI: begin
        mul_a = {19'd0, var_r[63:48]};
        mul_b = {16'd0, gain_c};
      end
      default: mul_en = 1'b0;
    endcase
    mul_p = mul_a * mul_b;
  end

  // rounding shifts, half away from zero
  always_comb begin
    dsum  = 57'(prod_r) + 57'sd8388608 - 57'(prod_r[55]);
    delta = dsum[56:24];
    csum  = 53'(prod_r) + 53'sd32768 - 53'(prod_r[51]);
    corr  = csum[52:16];
    fused_w = 37'(prior_r) + corr;
    var_sum = {1'b0, var_r} + {1'b0, prod_r[63:0]};
    rem_sh  = {rem_r, 1'b0};
    div_ge  = rem_sh >= {1'b0, den_r};
    sq_t    = sq_res_r + sq_bit_r;
    sq_ge   = sq_n_r >= sq_t;
  end

  always_comb begin
    period_nxt = period_r;
    qn_nxt     = qn_r;
    rn_nxt     = rn_r;
    est_nxt    = est_r;
    dev_nxt    = dev_r;
    rate_nxt   = rate_r;
    meas_nxt   = meas_r;
    prod_nxt   = mul_en ? mul_p : prod_r;
    prior_nxt  = prior_r;
    var_nxt    = var_r;
    rem_nxt    = rem_r;
    den_nxt    = den_r;
    frac_nxt   = frac_r;
    sq_n_nxt   = sq_n_r;
    sq_res_nxt = sq_res_r;
    sq_bit_nxt = sq_bit_r;
    gain_nxt   = gain_r;
    diff_nxt   = diff_r;
    fused_nxt  = fused_r;
    acc_nxt    = acc_r;
    out_fused_nxt = out_fused_r;
    out_gain_nxt  = out_gain_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cfg_we) begin
      case (cfg_index)
        CfgPeriod: period_nxt = cfg_data[PeriodW-1:0];
        CfgQnoise: qn_nxt     = cfg_data[NoiseW-1:0];
        CfgRnoise: rn_nxt     = cfg_data[NoiseW-1:0];
        default:   ;
      endcase
    end

    case (cmd.op)
      OP_LOAD_IN: begin
        rate_nxt = in_angle_rate;
        meas_nxt = in_accel_angle;
      end
      OP_MUL_PP:  prior_nxt = 34'(est_r) + 34'(delta);
      OP_MUL_QQ:  var_nxt   = prod_r[63:0];
      OP_MUL_RR:  var_nxt   = var_sum[64] ? '1 : var_sum[63:0];
      OP_DIV_SET: begin
        rem_nxt  = {1'b0, var_r[63:2]};
        den_nxt  = {1'b0, var_r[63:2]} + {1'b0, r2q};
        frac_nxt = '0;
        if (r2q == '0 && var_r[63:2] != '0) frac_nxt = 33'h1_0000_0000;
      end
      OP_DIV_STEP: begin
        rem_nxt  = div_ge ? 63'(rem_sh - {1'b0, den_r}) : rem_sh[62:0];
        frac_nxt = {frac_r[31:0], div_ge};
      end
      OP_SQRT_K_INIT: begin
        sq_n_nxt   = {31'd0, frac_r};
        sq_res_nxt = '0;
        sq_bit_nxt = 64'h4000_0000_0000_0000;
      end
      OP_SQRT_STEP: begin
        if (sq_ge) begin
          sq_n_nxt   = sq_n_r - sq_t;
          sq_res_nxt = (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_nxt = sq_res_r >> 1;
        end
        sq_bit_nxt = sq_bit_r >> 2;
      end
      OP_GAIN: begin
        gain_nxt = sq_res_r[GainW-1:0];
        diff_nxt = 35'(meas_r) - 35'(prior_r);
      end
      OP_MUL_LO: begin
        if (fused_w > 37'sd2147483647)       fused_nxt = 32'sh7FFF_FFFF;
        else if (fused_w < -37'sd2147483648) fused_nxt = 32'sh8000_0000;
        else                                 fused_nxt = fused_w[31:0];
      end
      OP_MUL_HI:  acc_nxt = prod_r[48:0];
      OP_SQRT_P_INIT: begin
        sq_n_nxt   = {prod_r[31:0], 32'd0} + {15'd0, acc_r};
        sq_res_nxt = '0;
        sq_bit_nxt = 64'h4000_0000_0000_0000;
      end
      OP_COMMIT: begin
        est_nxt       = fused_r;
        dev_nxt       = sq_res_r[31:0];
        out_fused_nxt = fused_r;
        out_gain_nxt  = gain_r;
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PeriodReset;
      qn_r        <= QnoiseReset;
      rn_r        <= RnoiseReset;
      est_r       <= '0;
      dev_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      period_r    <= period_nxt;
      qn_r        <= qn_nxt;
      rn_r        <= rn_nxt;
      est_r       <= est_nxt;
      dev_r       <= dev_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rate_r      <= rate_nxt;
    meas_r      <= meas_nxt;
    prod_r      <= prod_nxt;
    prior_r     <= prior_nxt;
    var_r       <= var_nxt;
    rem_r       <= rem_nxt;
    den_r       <= den_nxt;
    frac_r      <= frac_nxt;
    sq_n_r      <= sq_n_nxt;
    sq_res_r    <= sq_res_nxt;
    sq_bit_r    <= sq_bit_nxt;
    gain_r      <= gain_nxt;
    diff_r      <= diff_nxt;
    fused_r     <= fused_nxt;
    acc_r       <= acc_nxt;
    out_fused_r <= out_fused_nxt;
    out_gain_r  <= out_gain_nxt;
  end

  assign status.div_skip  = (r2q == '0);
  assign status.out_free  = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_fused_angle  = out_fused_r;
  assign out_filter_gain  = out_gain_r;

endmodule

[sv/scalar_kalman_angle_fusion_top.sv]
`timescale 1ns / 1ps
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | in_angle_rate, in_accel_angle (Q16.16)
// out     | output    | out_valid/out_stall| out_fused_angle (Q16.16), out_filter_gain (Q1.16)
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One word at a time: the next word is taken once the previous result has been
// registered. The gain divide is skipped when the gain settles without it. The
// 32-step gain divide and the two 32-step square roots on the shared root unit
// make up most of the work per word.
// Reset (rst_n low, synchronous) restores register defaults and zeroes the state.
// The output register holds a finished word under out_stall; the next input word
// is taken meanwhile and its result waits in the final state until the slot frees.
module scalar_kalman_angle_fusion_top
  import skaf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DataW-1:0]  in_angle_rate,
  input  logic signed [DataW-1:0]  in_accel_angle,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DataW-1:0]  out_fused_angle,
  output logic [GainW-1:0]         out_filter_gain,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [DataW-1:0]         cfg_data
);

  cmd_t    cmd;
  status_t status;

  // registers take a write in any cycle; out-of-range indexes are dropped
  assign cfg_ready = 1'b1;

  // sequencer: walks predict, variance, divide (skipped when R*R/4 is zero), gain root, correct, deviation root
  skaf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: one shared multiplier, restoring divider, bit-pair square root
  skaf_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_angle_rate   (in_angle_rate),
    .in_accel_angle  (in_accel_angle),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_fused_angle (out_fused_angle),
    .out_filter_gain (out_filter_gain)
  );

endmodule
